[rtl/core/scm_pkg.sv]
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths and types for the speaker channel mixer core.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int SAMPLE_W = 16;
    // Pre-scaled unity/half/quarter sum: 4 * (dst + src) or a down-mix sum.
    localparam int A_W      = 20;
    // Sum of up to two samples that is scaled by sqrt(1/2).
    localparam int K_W      = 17;
    localparam int PROD_W   = 34;
    localparam int ACC_W    = 36;
    localparam int NUM_CH   = 6;

    // sqrt(1/2) as unsigned Q0.16.
    localparam logic [15:0] SQRT_HALF_Q16 = 16'd46341;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [A_W-1:0]      acc_a_t;
    typedef logic signed [K_W-1:0]      acc_k_t;

    // Load enables for the multiply and round stages of every lane.
    typedef struct packed {
        logic ld_mul;
        logic ld_rnd;
    } lane_ctl_t;

endpackage

[rtl/core/scm_lane.sv]
// ----------------------------------------------------------------------------
// scm_lane
// One output channel: multiplies the sqrt(1/2) term, then adds, rounds to
// Q1.15 and saturates. Two register stages.
// ----------------------------------------------------------------------------
module scm_lane (
    input  logic               aclk,
    input  scm_pkg::lane_ctl_t ctl,
    input  scm_pkg::acc_a_t    a_in,
    input  scm_pkg::acc_k_t    k_in,
    output scm_pkg::sample_t   y_out
);
    import scm_pkg::*;

    acc_a_t                    a_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    sample_t                   y_reg;
    sample_t                   y_next;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-17:0]  shifted;

    assign prod_next = PROD_W'(k_in * $signed({1'b0, SQRT_HALF_Q16}));

    always_ff @(posedge aclk) begin
        if (ctl.ld_mul) begin
            a_reg    <= a_in;
            prod_reg <= prod_next;
        end
    end

    // The sum is scaled by 2^16; adding one half and dropping 16 bits rounds
    // to nearest with ties toward plus infinity.
    always_comb begin
        acc = {{(ACC_W-A_W-14){a_reg[A_W-1]}}, a_reg, 14'd0}
            + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg}
            + ACC_W'(32768);
        shifted = acc[ACC_W-1:16];
        if (shifted > $signed(20'sd32767)) begin
            y_next = 16'sh7fff;
        end else if (shifted < -$signed(20'sd32768)) begin
            y_next = 16'sh8000;
        end else begin
            y_next = shifted[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_rnd) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule

[rtl/core/speaker_channel_mixer_core.sv]
// ----------------------------------------------------------------------------
// speaker_channel_mixer_core
// Mixes a source frame of up to six Q1.15 channels into a destination frame,
// with speaker up/down-mix rules chosen by the configured channel counts.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  s_      | s_valid / s_ready  | s_src_s0..s_src_s5, s_dst_s0..s_dst_s5
//  m_      | m_valid / m_ready  | m_out_s0..m_out_s5
//  cfg_    | cfg_we (no wait)   | cfg_idx, cfg_wdata
//
// A word passes three register stages: route and pre-add, the sqrt(1/2)
// multiply, then round and saturate. m_valid rises when the word is in the
// round and saturate register. One word per cycle is sustained while m_ready
// is high. Each stage holds its word while the stage after it is
// full and stalled, so s_ready drops only when all three stages are full and
// m_ready is low. Reset clears the stage valid bits and loads the default
// configuration.
// ----------------------------------------------------------------------------
module speaker_channel_mixer_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_idx,
    input  logic [2:0]       cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  scm_pkg::sample_t s_src_s0,
    input  scm_pkg::sample_t s_src_s1,
    input  scm_pkg::sample_t s_src_s2,
    input  scm_pkg::sample_t s_src_s3,
    input  scm_pkg::sample_t s_src_s4,
    input  scm_pkg::sample_t s_src_s5,
    input  scm_pkg::sample_t s_dst_s0,
    input  scm_pkg::sample_t s_dst_s1,
    input  scm_pkg::sample_t s_dst_s2,
    input  scm_pkg::sample_t s_dst_s3,
    input  scm_pkg::sample_t s_dst_s4,
    input  scm_pkg::sample_t s_dst_s5,
    output logic             m_valid,
    input  logic             m_ready,
    output scm_pkg::sample_t m_out_s0,
    output scm_pkg::sample_t m_out_s1,
    output scm_pkg::sample_t m_out_s2,
    output scm_pkg::sample_t m_out_s3,
    output scm_pkg::sample_t m_out_s4,
    output scm_pkg::sample_t m_out_s5
);
    import scm_pkg::*;

    localparam logic [1:0] REG_SRC_CH = 2'd0;
    localparam logic [1:0] REG_DST_CH = 2'd1;
    localparam logic [1:0] REG_COPY   = 2'd2;

    localparam logic [3:0] MODE_UP_1_24  = 4'd0;
    localparam logic [3:0] MODE_UP_1_6   = 4'd1;
    localparam logic [3:0] MODE_UP_2_46  = 4'd2;
    localparam logic [3:0] MODE_UP_4_6   = 4'd3;
    localparam logic [3:0] MODE_DN_2_1   = 4'd4;
    localparam logic [3:0] MODE_DN_4_1   = 4'd5;
    localparam logic [3:0] MODE_DN_6_2   = 4'd6;
    localparam logic [3:0] MODE_DN_6_4   = 4'd7;
    localparam logic [3:0] MODE_DIRECT   = 4'd8;

    logic [2:0] src_ch_reg;
    logic [2:0] dst_ch_reg;
    logic       copy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_ch_reg <= 3'd2;
            dst_ch_reg <= 3'd2;
            copy_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_SRC_CH: src_ch_reg <= cfg_wdata;
                REG_DST_CH: dst_ch_reg <= cfg_wdata;
                REG_COPY:   copy_reg   <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // Counts of zero and seven are taken as one and six.
    logic [2:0] ns;
    logic [2:0] nd;
    logic [2:0] nmin;
    logic [3:0] mode;

    always_comb begin
        ns   = (src_ch_reg == 3'd0) ? 3'd1 : ((src_ch_reg == 3'd7) ? 3'd6 : src_ch_reg);
        nd   = (dst_ch_reg == 3'd0) ? 3'd1 : ((dst_ch_reg == 3'd7) ? 3'd6 : dst_ch_reg);
        nmin = (ns < nd) ? ns : nd;
        priority if (ns == 3'd1 && (nd == 3'd2 || nd == 3'd4)) begin
            mode = MODE_UP_1_24;
        end else if (ns == 3'd1 && nd == 3'd6) begin
            mode = MODE_UP_1_6;
        end else if (ns == 3'd2 && (nd == 3'd4 || nd == 3'd6)) begin
            mode = MODE_UP_2_46;
        end else if (ns == 3'd4 && nd == 3'd6) begin
            mode = MODE_UP_4_6;
        end else if (ns == 3'd2 && nd == 3'd1) begin
            mode = MODE_DN_2_1;
        end else if (ns == 3'd4 && nd == 3'd1) begin
            mode = MODE_DN_4_1;
        end else if (ns == 3'd6 && nd == 3'd2) begin
            mode = MODE_DN_6_2;
        end else if (ns == 3'd6 && nd == 3'd4) begin
            mode = MODE_DN_6_4;
        end else begin
            mode = MODE_DIRECT;
        end
    end

    // Handshake: a stage takes a new word when it is empty or its word moves on.
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    lane_ctl_t lane_ctl;

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v3_reg;

    assign lane_ctl.ld_mul = v1_reg && rdy2;
    assign lane_ctl.ld_rnd = v2_reg && rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: routing and pre-adds.
    sample_t          src_w [NUM_CH];
    sample_t          dst_w [NUM_CH];
    sample_t          p_sel [NUM_CH];
    acc_k_t           k_next[NUM_CH];
    acc_a_t           a_next[NUM_CH];
    acc_a_t           a1_reg[NUM_CH];
    acc_k_t           k1_reg[NUM_CH];
    logic signed [17:0] extra0;
    sample_t          d_use;
    logic signed [16:0] dp_sum;

    assign src_w[0] = s_src_s0;
    assign src_w[1] = s_src_s1;
    assign src_w[2] = s_src_s2;
    assign src_w[3] = s_src_s3;
    assign src_w[4] = s_src_s4;
    assign src_w[5] = s_src_s5;
    assign dst_w[0] = s_dst_s0;
    assign dst_w[1] = s_dst_s1;
    assign dst_w[2] = s_dst_s2;
    assign dst_w[3] = s_dst_s3;
    assign dst_w[4] = s_dst_s4;
    assign dst_w[5] = s_dst_s5;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            p_sel[i]  = '0;
            k_next[i] = '0;
        end
        extra0 = '0;
        unique case (mode)
            MODE_UP_1_24: begin
                p_sel[0] = src_w[0];
                p_sel[1] = src_w[0];
            end
            MODE_UP_1_6: begin
                p_sel[2] = src_w[0];
            end
            MODE_UP_2_46: begin
                p_sel[0] = src_w[0];
                p_sel[1] = src_w[1];
            end
            MODE_UP_4_6: begin
                p_sel[0] = src_w[0];
                p_sel[1] = src_w[1];
                p_sel[4] = src_w[2];
                p_sel[5] = src_w[3];
            end
            MODE_DN_2_1: begin
                // 0.5 * (L + R) at the 4x pre-scale is 2 * (L + R).
                extra0 = {{src_w[0][15], src_w[0]} + {src_w[1][15], src_w[1]}, 1'b0};
            end
            MODE_DN_4_1: begin
                extra0 = {{2{src_w[0][15]}}, src_w[0]} + {{2{src_w[1][15]}}, src_w[1]}
                       + {{2{src_w[2][15]}}, src_w[2]} + {{2{src_w[3][15]}}, src_w[3]};
            end
            MODE_DN_6_2: begin
                p_sel[0]  = src_w[0];
                p_sel[1]  = src_w[1];
                k_next[0] = {src_w[2][15], src_w[2]} + {src_w[4][15], src_w[4]};
                k_next[1] = {src_w[2][15], src_w[2]} + {src_w[5][15], src_w[5]};
            end
            MODE_DN_6_4: begin
                p_sel[0]  = src_w[0];
                p_sel[1]  = src_w[1];
                p_sel[2]  = src_w[4];
                p_sel[3]  = src_w[5];
                k_next[0] = {src_w[2][15], src_w[2]};
                k_next[1] = {src_w[2][15], src_w[2]};
            end
            MODE_DIRECT: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (3'(i) < nmin) begin
                        p_sel[i] = src_w[i];
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < NUM_CH; i++) begin
            d_use     = (3'(i) < nd && !copy_reg) ? dst_w[i] : '0;
            dp_sum    = {d_use[15], d_use} + {p_sel[i][15], p_sel[i]};
            a_next[i] = {{(A_W-19){dp_sum[16]}}, dp_sum, 2'b00};
            if (i == 0) begin
                a_next[i] = a_next[i] + {{(A_W-18){extra0[17]}}, extra0};
            end
            // Channels past the destination count come out as zero.
            if (3'(i) >= nd) begin
                a_next[i] = '0;
                k_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy1) begin
            for (int i = 0; i < NUM_CH; i++) begin
                a1_reg[i] <= a_next[i];
                k1_reg[i] <= k_next[i];
            end
        end
    end

    sample_t y_w[NUM_CH];

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        scm_lane u_lane (
            .aclk  (aclk),
            .ctl   (lane_ctl),
            .a_in  (a1_reg[g]),
            .k_in  (k1_reg[g]),
            .y_out (y_w[g])
        );
    end

    assign m_out_s0 = y_w[0];
    assign m_out_s1 = y_w[1];
    assign m_out_s2 = y_w[2];
    assign m_out_s3 = y_w[3];
    assign m_out_s4 = y_w[4];
    assign m_out_s5 = y_w[5];

`ifndef ASSERT_OFF
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && !m_ready) |-> !s_ready)
        else $error("input taken while the pipeline is full and stalled");

    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && v3_reg && !m_ready) |=> v2_reg)
        else $error("middle-stage word lost during a stall");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("word leaving stage one did not reach stage two");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !v1_reg && !v2_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule
